/* hw/rtl/ichc_pkg.sv */
// ----------------------------------------------------------------------------
// ichc_pkg
// Shared types, codes and constants of the image container header checker.
// ----------------------------------------------------------------------------
package ichc_pkg;

    localparam int LENGTH_BITS_DEF = 40;
    localparam int DIM_BITS_DEF    = 16;

    localparam logic [15:0] MAX_WIDTH_RST  = 16'd7680;
    localparam logic [15:0] MAX_HEIGHT_RST = 16'd4320;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [63:0] HDR_MIN    = 64'd36;
    localparam logic [7:0]  CHAR_NL    = 8'h0A;
    localparam logic [7:0]  CHAR_NUL   = 8'h00;
    localparam logic [7:0]  ASCII_MASK = 8'h7F;

    localparam logic [7:0] MAGIC_0 = 8'h43;
    localparam logic [7:0] MAGIC_1 = 8'h49;
    localparam logic [7:0] MAGIC_2 = 8'h46;
    localparam logic [7:0] MAGIC_3 = 8'h46;

    localparam logic [3:0] KIND_MAGIC       = 4'd0;
    localparam logic [3:0] KIND_HSIZE       = 4'd1;
    localparam logic [3:0] KIND_CSIZE       = 4'd2;
    localparam logic [3:0] KIND_WIDTH       = 4'd3;
    localparam logic [3:0] KIND_HEIGHT      = 4'd4;
    localparam logic [3:0] KIND_CAPTION     = 4'd5;
    localparam logic [3:0] KIND_CAPTION_END = 4'd6;
    localparam logic [3:0] KIND_TAG         = 4'd7;
    localparam logic [3:0] KIND_TAG_END     = 4'd8;
    localparam logic [3:0] KIND_PIXEL       = 4'd9;

    localparam logic [1:0] COLOR_RED  = 2'd0;
    localparam logic [1:0] COLOR_BLUE = 2'd2;

    typedef enum logic [1:0] {
        ST_BUSY   = 2'd0,
        ST_OK     = 2'd1,
        ST_FORMAT = 2'd2,
        ST_SIZE   = 2'd3
    } t_status;

    typedef enum logic [8:0] {
        PH_MAGIC   = 9'b000000001,
        PH_HSIZE   = 9'b000000010,
        PH_CSIZE   = 9'b000000100,
        PH_WIDTH   = 9'b000001000,
        PH_HEIGHT  = 9'b000010000,
        PH_CAPTION = 9'b000100000,
        PH_TAGS    = 9'b001000000,
        PH_PIXELS  = 9'b010000000,
        PH_DONE    = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic [3:0] kind;
        logic [1:0] color;
        t_status    verdict;
    } t_rec;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        unique case (idx)
            2'd0:    m = MAGIC_0;
            2'd1:    m = MAGIC_1;
            2'd2:    m = MAGIC_2;
            default: m = MAGIC_3;
        endcase
        return m;
    endfunction

endpackage

/* hw/rtl/image_container_header_checker_core.sv */
// ----------------------------------------------------------------------------
// image_container_header_checker_core
// Streaming checker for an RGB image container, one byte per item.
//
// Input channel (valid/ready): one file byte, a first-byte flag and the file
// length, sampled on the first byte. Output channel (valid/ready): the byte
// passed through with its kind, its pixel color and the running status.
// Throughput is one byte per cycle while the queue has room; the per-byte
// parser loop in the front has no stall of its own. An accepted item goes
// into the item queue and is then loaded into the output register, where
// output valid rises. When the receiver stalls, the output register and the
// two-entry queue fill and input ready drops with a full queue; no item is
// lost. Limits are to be written through the config port while the block is
// idle; the block itself does not enforce it.
// Reset: limits go to 7680 by 4320, the parser to the magic bytes, the status
// to in progress, queue and output register empty.
// ----------------------------------------------------------------------------
module image_container_header_checker_core
    import ichc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int DIM_BITS    = DIM_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_first_byte,
    input  logic [LENGTH_BITS-1:0] i_file_length,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [3:0]             o_byte_kind,
    output logic [7:0]             o_byte_out,
    output logic [1:0]             o_color,
    output logic [1:0]             o_status,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [15:0] r_max_width;
    logic [15:0] r_max_height;
    logic        front_valid;
    t_rec        front_rec;
    logic        q_valid;
    logic        q_ready;
    t_rec        q_rec;
    logic        back_ready;
    t_status     out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width  <= MAX_WIDTH_RST;
            r_max_height <= MAX_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAX_WIDTH:  r_max_width  <= i_cfg_data;
                REG_MAX_HEIGHT: r_max_height <= i_cfg_data;
                default:        r_max_width  <= r_max_width;
            endcase
        end
    end

    ichc_front #(
        .LENGTH_BITS (LENGTH_BITS),
        .DIM_BITS    (DIM_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_q_ready     (q_ready),
        .i_data_byte   (i_data_byte),
        .i_first_byte  (i_first_byte),
        .i_file_length (i_file_length),
        .i_max_width   (r_max_width),
        .i_max_height  (r_max_height),
        .o_valid       (front_valid),
        .o_rec         (front_rec)
    );

    ichc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (q_ready),
        .i_rec   (front_rec),
        .o_valid (q_valid),
        .i_ready (back_ready),
        .o_rec   (q_rec)
    );

    ichc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_ready     (back_ready),
        .i_rec       (q_rec),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_byte_kind (o_byte_kind),
        .o_byte_out  (o_byte_out),
        .o_color     (o_color),
        .o_status    (out_status)
    );

    assign o_in_ready = q_ready;
    assign o_status   = out_status;

    a_color_only_pixels: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_byte_kind != KIND_PIXEL)) |-> (o_color == COLOR_RED)
    ) else $error("color set on a non-pixel item");

    a_ok_kind: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_OK)) |->
            ((o_byte_kind == KIND_PIXEL) || (o_byte_kind == KIND_MAGIC))
    ) else $error("valid status on a header item");

    a_reset_empty: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !o_out_valid
    ) else $error("output valid right after reset");

endmodule

/* hw/rtl/ichc_front.sv */
// ----------------------------------------------------------------------------
// ichc_front
// Byte parser: counts bytes, tracks the file section, assembles the header
// fields and works out each byte's kind, color and verdict.
// ----------------------------------------------------------------------------
module ichc_front
    import ichc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int DIM_BITS    = DIM_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_q_ready,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_first_byte,
    input  logic [LENGTH_BITS-1:0] i_file_length,
    input  logic [15:0]            i_max_width,
    input  logic [15:0]            i_max_height,
    output logic                   o_valid,
    output t_rec                   o_rec
);

    localparam int DIM_BYTES = (DIM_BITS + 7) / 8;
    localparam int PW        = DIM_BITS + 2 + 8 * DIM_BYTES;
    localparam logic [31:0] DIM_MASK = 32'hFFFF_FFFF >> (32 - DIM_BITS);

    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic [LENGTH_BITS-1:0] r_total;
    t_phase                 r_phase, n_phase;
    logic [1:0]             r_color, n_color;
    logic [55:0]            r_field, n_field;
    logic [LENGTH_BITS-1:0] r_hdr, n_hdr;
    logic                   r_hdr_bad, n_hdr_bad;
    logic                   r_hdr36, n_hdr36;
    logic [LENGTH_BITS-1:0] r_diff, n_diff;
    logic [LENGTH_BITS-1:0] r_content, n_content;
    logic [DIM_BITS-1:0]    r_width, n_width;
    logic [PW-1:0]          r_prod, n_prod;

    logic                   accept;
    logic [LENGTH_BITS-1:0] c_count;
    logic [LENGTH_BITS-1:0] c_total;
    t_phase                 c_phase;
    logic [1:0]             c_color;
    logic [LENGTH_BITS:0]   cnt_p1;
    logic                   beyond;
    logic                   last_eq;
    logic                   last_hdr;
    logic [2:0]             k;
    logic [7:0]             b;
    logic [63:0]            v64;
    logic [LENGTH_BITS+63:0] total_x, diff_x, content_x;
    logic [PW+63:0]          prod_x;
    logic [DIM_BITS+1:0]    three_w;
    logic [DIM_BITS+9:0]    partial;
    logic [PW-1:0]          part_ext;
    logic [3:0]             kind;
    logic [1:0]             color;
    t_status                verdict;

    function automatic logic dim_ok(input logic [63:0] v, input logic [15:0] lim_reg);
        logic [31:0] lim;
        logic [31:0] lo;
        logic [63:0] hi;
        lim = {16'd0, lim_reg};
        if (lim > DIM_MASK) begin
            lim = DIM_MASK;
        end
        lo = v[31:0] & DIM_MASK;
        hi = v >> DIM_BITS;
        return (hi == 64'd0) && (lo != 32'd0) && (lo <= lim);
    endfunction

    assign accept  = i_valid && i_q_ready;
    assign c_count = i_first_byte ? '0 : r_count;
    assign c_total = i_first_byte ? i_file_length : r_total;
    assign c_phase = i_first_byte ? PH_MAGIC : r_phase;
    assign c_color = i_first_byte ? COLOR_RED : r_color;
    assign b       = i_data_byte;

    assign cnt_p1   = {1'b0, c_count} + {{LENGTH_BITS{1'b0}}, 1'b1};
    assign beyond   = c_count >= c_total;
    assign last_eq  = cnt_p1 == {1'b0, c_total};
    assign last_hdr = cnt_p1 == {1'b0, r_hdr};
    // fields start at byte four
    assign k        = c_count[2:0] ^ 3'b100;

    assign v64       = {b, r_field};
    assign total_x   = {64'd0, c_total};
    assign diff_x    = {64'd0, r_diff};
    assign content_x = {64'd0, r_content};
    assign prod_x    = {64'd0, r_prod};

    assign three_w  = ({2'b00, r_width} << 1) + {2'b00, r_width};
    assign partial  = {8'd0, three_w} * {{(DIM_BITS+2){1'b0}}, b};
    assign part_ext = PW'(partial);

    always_comb begin
        n_field = r_field;
        for (int i = 0; i < 7; i++) begin
            if (k == 3'(i)) begin
                n_field[8*i +: 8] = b;
            end else if (k == 3'd0) begin
                n_field[8*i +: 8] = 8'd0;
            end
        end
    end

    always_comb begin
        n_count   = (c_count == '1) ? c_count : cnt_p1[LENGTH_BITS-1:0];
        n_phase   = c_phase;
        n_color   = c_color;
        n_hdr     = r_hdr;
        n_hdr_bad = r_hdr_bad;
        n_hdr36   = r_hdr36;
        n_diff    = r_diff;
        n_content = r_content;
        n_width   = r_width;
        n_prod    = r_prod;
        kind      = KIND_MAGIC;
        color     = COLOR_RED;
        verdict   = ST_BUSY;
        if (beyond) begin
            verdict = ST_FORMAT;
        end else begin
            unique case (c_phase)
                PH_MAGIC: begin
                    if (b != magic_byte(c_count[1:0])) begin
                        verdict = ST_FORMAT;
                    end
                    if (c_count[1:0] == 2'd3) begin
                        n_phase = PH_HSIZE;
                    end
                end
                PH_HSIZE: begin
                    kind = KIND_HSIZE;
                    if (k == 3'd7) begin
                        n_hdr     = v64[LENGTH_BITS-1:0];
                        n_hdr_bad = (v64 > total_x[63:0]) || (v64 < HDR_MIN);
                        n_hdr36   = v64 == HDR_MIN;
                        n_diff    = c_total - v64[LENGTH_BITS-1:0];
                        n_phase   = PH_CSIZE;
                    end
                end
                PH_CSIZE: begin
                    kind = KIND_CSIZE;
                    if (k == 3'd7) begin
                        if (r_hdr_bad || (v64 != diff_x[63:0])) begin
                            verdict = ST_FORMAT;
                        end
                        n_content = v64[LENGTH_BITS-1:0];
                        n_phase   = PH_WIDTH;
                    end
                end
                PH_WIDTH: begin
                    kind = KIND_WIDTH;
                    if (k == 3'd7) begin
                        if (!dim_ok(v64, i_max_width)) begin
                            verdict = ST_SIZE;
                        end
                        n_width = v64[DIM_BITS-1:0];
                        n_phase = PH_HEIGHT;
                    end
                end
                PH_HEIGHT: begin
                    kind = KIND_HEIGHT;
                    // 3 * width * height built one height byte at a time
                    if (k == 3'd0) begin
                        n_prod = part_ext;
                    end else if (k < 3'(DIM_BYTES)) begin
                        n_prod = r_prod + (part_ext << {k, 3'b000});
                    end
                    if (k == 3'd7) begin
                        if (!dim_ok(v64, i_max_height)) begin
                            verdict = ST_SIZE;
                        end else if ((prod_x[63:0] != content_x[63:0]) || r_hdr36) begin
                            verdict = ST_FORMAT;
                        end
                        n_phase = PH_CAPTION;
                    end
                end
                PH_CAPTION: begin
                    if (b == CHAR_NL) begin
                        kind    = KIND_CAPTION_END;
                        n_phase = last_hdr ? PH_PIXELS : PH_TAGS;
                    end else begin
                        kind = KIND_CAPTION;
                        if (((b & ~ASCII_MASK) != 8'd0) || last_hdr) begin
                            verdict = ST_FORMAT;
                        end
                    end
                end
                PH_TAGS: begin
                    if (b == CHAR_NUL) begin
                        kind = KIND_TAG_END;
                        if (last_hdr) begin
                            n_phase = PH_PIXELS;
                        end
                    end else begin
                        kind = KIND_TAG;
                        if (((b & ~ASCII_MASK) != 8'd0) || (b == CHAR_NL) || last_hdr) begin
                            verdict = ST_FORMAT;
                        end
                    end
                end
                PH_PIXELS: begin
                    kind    = KIND_PIXEL;
                    color   = c_color;
                    n_color = (c_color >= COLOR_BLUE) ? COLOR_RED : c_color + 2'd1;
                    if (last_eq) begin
                        verdict = ST_OK;
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    verdict = ST_FORMAT;
                end
            endcase
            // file ended before parsing finished
            if ((verdict == ST_BUSY) && last_eq) begin
                verdict = ST_FORMAT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_phase <= PH_MAGIC;
            r_color <= COLOR_RED;
        end else if (accept) begin
            r_count <= n_count;
            r_total <= c_total;
            r_phase <= n_phase;
            r_color <= n_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_field   <= n_field;
            r_hdr     <= n_hdr;
            r_hdr_bad <= n_hdr_bad;
            r_hdr36   <= n_hdr36;
            r_diff    <= n_diff;
            r_content <= n_content;
            r_width   <= n_width;
            r_prod    <= n_prod;
        end
    end

    assign o_valid       = i_valid;
    assign o_rec.data    = b;
    assign o_rec.start   = i_first_byte;
    assign o_rec.kind    = kind;
    assign o_rec.color   = color;
    assign o_rec.verdict = verdict;

endmodule

/* hw/rtl/ichc_queue.sv */
// ----------------------------------------------------------------------------
// ichc_queue
// Short FIFO of classified items between the parser and the output stage.
// ----------------------------------------------------------------------------
module ichc_queue
    import ichc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_rec i_rec,
    output logic o_valid,
    input  logic i_ready,
    output t_rec o_rec
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_rec             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             push;
    logic             pop;

    assign o_ready = r_cnt != CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_rec   = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (push) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

endmodule

/* hw/rtl/ichc_back.sv */
// ----------------------------------------------------------------------------
// ichc_back
// Output stage: latches the file status and drives the result register.
// ----------------------------------------------------------------------------
module ichc_back
    import ichc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_rec       i_rec,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_byte_kind,
    output logic [7:0] o_byte_out,
    output logic [1:0] o_color,
    output t_status    o_status
);

    logic       r_out_valid;
    t_status    r_status, n_status;
    logic [3:0] r_kind, n_kind;
    logic [7:0] r_byte;
    logic [1:0] r_color, n_color;
    t_status    r_out_status;
    t_status    cur;
    logic       take;

    assign o_ready = !r_out_valid || i_out_ready;
    assign take    = i_valid && o_ready;
    assign cur     = i_rec.start ? ST_BUSY : r_status;

    always_comb begin
        if (cur == ST_BUSY) begin
            n_kind   = i_rec.kind;
            n_color  = i_rec.color;
            n_status = i_rec.verdict;
        end else begin
            // status held until the next file
            n_kind   = KIND_MAGIC;
            n_color  = COLOR_RED;
            n_status = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_status    <= ST_BUSY;
        end else begin
            if (take) begin
                r_out_valid <= 1'b1;
                r_status    <= n_status;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind       <= n_kind;
            r_byte       <= i_rec.data;
            r_color      <= n_color;
            r_out_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_byte_kind = r_kind;
    assign o_byte_out  = r_byte;
    assign o_color     = r_color;
    assign o_status    = r_out_status;

endmodule
